// ===== hdl/hcb_pkg.sv =====
// shared types and codes for the huffman code builder
package hcb_pkg;

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  code_length;
		logic [63:0] code_bits;
		logic        overflow;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic cnt_wr;
		logic init_step;
		logic scan_start;
		logic scan_cmp;
		logic take_wr;
		logic merge_wr;
		logic walk_rd;
		logic walk_step;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic sym_ok;
		logic init_last;
		logic hit;
		logic need_merge;
		logic scan_last;
		logic second;
		logic at_root;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/hcb_datapath.sv =====
// count table, tree node store, scan and walk registers, result register
module hcb_datapath #(
	parameter int SYMBOLS     = 256,
	parameter int COUNT_WIDTH = 32,
	parameter int MAX_CODE    = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hcb_pkg::req_t req,
	input  hcb_pkg::cmd_t cmd,
	output hcb_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hcb_pkg::rsp_t rsp
);
	import hcb_pkg::*;

	localparam int SW    = $clog2(SYMBOLS);
	localparam int IW    = $clog2(SYMBOLS + 1);
	localparam int NODES = 2 * SYMBOLS - 1;
	localparam int NW    = $clog2(NODES);
	localparam int XW    = $clog2(NODES + 1);
	localparam int WW    = COUNT_WIDTH + SW;
	localparam int DW    = SW + 1;

	typedef struct packed {
		logic [WW-1:0] w;
		logic          alive;
		logic [NW-1:0] parent;
		logic          left;
	} node_t;

	logic [COUNT_WIDTH-1:0] cnt_mem [SYMBOLS];
	logic [SYMBOLS-1:0]     vld_q;
	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic                   cnt_vld_q;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [SW-1:0]          cnt_addr;

	node_t         node_mem [NODES];
	node_t         nd_q;
	logic          nwe;
	logic [NW-1:0] nwa;
	node_t         nwd;
	logic [NW-1:0] nra;
	logic [NW-1:0] scan_idx;
	logic [XW-1:0] ni;
	logic [XW-1:0] root_x;

	logic [SW-1:0]       sym_q;
	logic [IW-1:0]       i_q;
	logic [XW-1:0]       n_q;
	logic [XW-1:0]       next_q;
	logic [XW-1:0]       p_q;
	logic                hit_q;
	logic [NW-1:0]       cur_q;
	logic [NW-1:0]       idx_q;
	logic [NW-1:0]       best_idx_q;
	logic [WW-1:0]       best_w_q;
	logic [WW-1:0]       right_w_q;
	logic                have_q;
	logic                second_q;
	logic [DW-1:0]       depth_q;
	logic [MAX_CODE-1:0] bits_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic                ovf;

	assign cnt_addr = cmd.accept ? req.value[SW-1:0] : i_q[SW-1:0];
	assign cnt_cur  = cnt_vld_q ? cnt_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr && !(&cnt_cur))
			cnt_mem[sym_q] <= cnt_cur + 1'b1;
		cnt_rd_q  <= cnt_mem[cnt_addr];
		cnt_vld_q <= vld_q[cnt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear) begin
			vld_q <= '0;
		end else if (cmd.cnt_wr) begin
			vld_q[sym_q] <= 1'b1;
		end
	end

	// list order: merged nodes newest first, then leaves ascending
	assign ni       = next_q - n_q;
	assign scan_idx = (p_q < ni) ? NW'(next_q - 1'b1 - p_q) : NW'(p_q - ni);
	assign nra      = cmd.walk_rd ? cur_q : scan_idx;
	assign root_x   = next_q - 1'b1;

	always_comb begin
		nwe = 1'b0;
		nwa = n_q[NW-1:0];
		nwd = '0;
		if (cmd.init_step && (cnt_cur != '0)) begin
			nwe   = 1'b1;
			nwd.w = WW'(cnt_cur);
			nwd.alive = 1'b1;
		end
		if (cmd.take_wr) begin
			nwe        = 1'b1;
			nwa        = best_idx_q;
			nwd.w      = best_w_q;
			nwd.parent = next_q[NW-1:0];
			nwd.left   = second_q;
		end
		if (cmd.merge_wr) begin
			nwe       = 1'b1;
			nwa       = next_q[NW-1:0];
			nwd.w     = right_w_q + best_w_q;
			nwd.alive = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (nwe)
			node_mem[nwa] <= nwd;
		nd_q  <= node_mem[nra];
		idx_q <= scan_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q      <= '0;
			i_q        <= '0;
			n_q        <= '0;
			next_q     <= '0;
			p_q        <= '0;
			hit_q      <= 1'b0;
			cur_q      <= '0;
			best_idx_q <= '0;
			best_w_q   <= '0;
			right_w_q  <= '0;
			have_q     <= 1'b0;
			second_q   <= 1'b0;
			depth_q    <= '0;
			bits_q     <= '0;
		end else begin
			if (cmd.accept) begin
				sym_q    <= req.value[SW-1:0];
				i_q      <= '0;
				n_q      <= '0;
				next_q   <= '0;
				hit_q    <= 1'b0;
				second_q <= 1'b0;
				depth_q  <= '0;
				bits_q   <= '0;
			end
			if (cmd.init_step) begin
				i_q <= i_q + 1'b1;
				if (cnt_cur != '0) begin
					n_q    <= n_q + 1'b1;
					next_q <= next_q + 1'b1;
					if (i_q[SW-1:0] == sym_q) begin
						hit_q <= 1'b1;
						cur_q <= n_q[NW-1:0];
					end
				end
			end
			if (cmd.scan_start) begin
				p_q    <= '0;
				have_q <= 1'b0;
			end
			if (cmd.scan_cmp) begin
				p_q <= p_q + 1'b1;
				if (nd_q.alive && (!have_q || (nd_q.w < best_w_q))) begin
					have_q     <= 1'b1;
					best_w_q   <= nd_q.w;
					best_idx_q <= idx_q;
				end
			end
			if (cmd.take_wr) begin
				second_q <= !second_q;
				if (!second_q)
					right_w_q <= best_w_q;
			end
			if (cmd.merge_wr)
				next_q <= next_q + 1'b1;
			if (cmd.walk_step) begin
				bits_q  <= {bits_q[MAX_CODE-2:0], nd_q.left};
				cur_q   <= nd_q.parent;
				depth_q <= depth_q + 1'b1;
			end
		end
	end

	assign ovf = (int'(depth_q) > MAX_CODE);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.found       <= hit_q;
			rsp_q.code_length <= ovf ? 7'(MAX_CODE) : 7'(depth_q);
			rsp_q.code_bits   <= 64'(bits_q);
			rsp_q.overflow    <= ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;
	assign sts.sym_ok     = (int'(req.value) < SYMBOLS);
	assign sts.init_last  = (i_q == IW'(SYMBOLS - 1));
	assign sts.hit        = hit_q;
	assign sts.need_merge = (({1'b0, next_q} + 1'b1) < {n_q, 1'b0});
	assign sts.scan_last  = (p_q == root_x);
	assign sts.second     = second_q;
	assign sts.at_root    = (cur_q == root_x[NW-1:0]);
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

endmodule

// ===== hdl/hcb_ctrl.sv =====
// sequencing state machine for counting, tree build and code walk
module hcb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    operation,
	input  hcb_pkg::sts_t sts,
	output hcb_pkg::cmd_t cmd,
	output logic          req_stall
);
	import hcb_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CNT_WR   = 4'd1;
	localparam logic [3:0] S_INIT_RD  = 4'd2;
	localparam logic [3:0] S_INIT_ST  = 4'd3;
	localparam logic [3:0] S_CHECK    = 4'd4;
	localparam logic [3:0] S_SCAN_RD  = 4'd5;
	localparam logic [3:0] S_SCAN_CMP = 4'd6;
	localparam logic [3:0] S_TAKE_WR  = 4'd7;
	localparam logic [3:0] S_MERGE_WR = 4'd8;
	localparam logic [3:0] S_WALK_RD  = 4'd9;
	localparam logic [3:0] S_WALK_ST  = 4'd10;
	localparam logic [3:0] S_RESULT   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (operation)
						OP_COUNT: if (sts.sym_ok) state_d = S_CNT_WR;
						OP_QUERY: state_d = sts.sym_ok ? S_INIT_RD : S_RESULT;
						OP_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			S_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_INIT_RD: state_d = S_INIT_ST;
			S_INIT_ST: begin
				cmd.init_step = 1'b1;
				state_d       = sts.init_last ? S_CHECK : S_INIT_RD;
			end
			S_CHECK: begin
				if (!sts.hit) begin
					state_d = S_RESULT;
				end else if (sts.need_merge) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_RD;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = sts.scan_last ? S_TAKE_WR : S_SCAN_RD;
			end
			S_TAKE_WR: begin
				cmd.take_wr = 1'b1;
				if (!sts.second) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_RD;
				end else begin
					state_d = S_MERGE_WR;
				end
			end
			S_MERGE_WR: begin
				cmd.merge_wr = 1'b1;
				state_d      = S_CHECK;
			end
			S_WALK_RD: begin
				if (sts.at_root) begin
					state_d = S_RESULT;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_ST;
				end
			end
			S_WALK_ST: begin
				cmd.walk_step = 1'b1;
				state_d       = S_WALK_RD;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== hdl/huffman_code_builder_unit.sv =====
// huffman code builder top level
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | operation, value
//  rsp     | out       | rsp_valid / rsp_stall | found, code_length, code_bits, overflow
// a count request reads the count table, then writes it; a clear empties it on acceptance
// a query reads every count table entry to load the present symbols, then for each of the
// n-1 merges makes two scans over every node slot allocated so far plus bookkeeping,
// then reads one node per code bit on the walk to the root; the single read port
// of the node store paces the scans and the walk
// reset empties the count table at once through per-entry valid flags
// a waiting result does not block the next request; a query result waits on rsp_stall
module huffman_code_builder_unit #(
	parameter int SYMBOLS     = 256,
	parameter int COUNT_WIDTH = 32,
	parameter int MAX_CODE    = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hcb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hcb_pkg::rsp_t rsp
);
	import hcb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (req.operation),
		.sts       (sts),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	hcb_datapath #(
		.SYMBOLS     (SYMBOLS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_CODE    (MAX_CODE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.code_length) <= MAX_CODE))
		else $error("code length beyond limit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |->
		(rsp.code_length == '0 && rsp.code_bits == '0 && !rsp.overflow))
		else $error("absent symbol with a code");

	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.overflow) |-> (int'(rsp.code_length) == MAX_CODE))
		else $error("overflow without full length");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> rsp_valid)
		else $error("result dropped while stalled");

endmodule
